FILE: rtl/core/gapf_pkg.sv
// shared types and constants for the grid path finder core
package gapf_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_FIND  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    localparam logic [2:0] ST_WRITTEN  = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_NO_PATH  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    localparam int COORD_W = 8;
    localparam int COST_W  = 16;

endpackage

FILE: rtl/core/grid_astar_path_finder_core.sv
// grid a* path finder: wall map, open/closed lists and path store in block memories
//
// input channel (valid/stall) takes one command word: write wall cell, find path,
// or read path step. output channel (out_valid/out_stall) returns one result word
// per command: status, path_length, step_x, step_y.
// a write, an unknown command, an out-of-range read or a find whose start is off the
// grid has its result valid in the cycle after acceptance; a read in range first
// reads the path store in S_RDPATH and then registers its result. a find is
// sequenced over the list memories one entry at a time: each expanded node costs a
// scan of the open list, a shift of the open list over the popped entry, and for
// each of four neighbors a bounds test and wall map read, then for a free cell a
// scan of the closed list; path build-back reads the closed list once per step.
// after reset a clearing pass zeroes all GRID_COLS*GRID_ROWS cells of the wall map;
// no command is accepted during it. one command is handled at a time; the result
// is held in an output register while the receiver stalls, and a new command is
// accepted once the previous result has been taken.
module grid_astar_path_finder_core #(
    parameter int GRID_COLS  = 32,
    parameter int GRID_ROWS  = 64,
    parameter int LIST_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [4:0] pos_x,
    input  logic [5:0] pos_y,
    input  logic       wall,
    input  logic [4:0] goal_x,
    input  logic [5:0] goal_y,
    input  logic [7:0] step_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [8:0] path_length,
    output logic [4:0] step_x,
    output logic [5:0] step_y
);
    import gapf_pkg::*;

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int MAP_AW = $clog2(CELLS);
    localparam int LA_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);

    typedef struct packed {
        logic [XW-1:0]     x;
        logic [YW-1:0]     y;
        logic [COST_W-1:0] g;
        logic [COST_W-1:0] f;
        logic [LA_W-1:0]   back;
        logic              has_back;
    } entry_t;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
    } cell_t;

    typedef enum logic [17:0] {
        S_CLEAR   = 18'h00001,
        S_IDLE    = 18'h00002,
        S_WMAP    = 18'h00004,
        S_RDPATH  = 18'h00008,
        S_SCAN    = 18'h00010,
        S_SCANW   = 18'h00020,
        S_POPRD   = 18'h00040,
        S_SHIFT   = 18'h00080,
        S_SHIFTW  = 18'h00100,
        S_CLOSE   = 18'h00200,
        S_NB      = 18'h00400,
        S_NBMAP   = 18'h00800,
        S_CSCAN   = 18'h01000,
        S_CSCANW  = 18'h02000,
        S_PUSH    = 18'h04000,
        S_BUILD   = 18'h08000,
        S_BUILDW  = 18'h10000,
        S_DONE    = 18'h20000
    } state_t;

    logic                wall_mem [CELLS];
    entry_t              open_mem [LIST_DEPTH];
    entry_t              closed_mem [LIST_DEPTH];
    cell_t               path_mem [LIST_DEPTH];

    state_t              state_reg, state_next;
    logic [MAP_AW:0]     clr_reg, clr_next;
    logic [CNT_W-1:0]    open_cnt_reg, open_cnt_next;
    logic [CNT_W-1:0]    closed_cnt_reg, closed_cnt_next;
    logic [CNT_W-1:0]    path_cnt_reg, path_cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    best_reg, best_next;
    logic [COST_W-1:0]   best_f_reg, best_f_next;
    entry_t              cur_reg, cur_next;
    logic [LA_W-1:0]     me_reg, me_next;
    logic [2:0]          nb_reg, nb_next;
    logic [COORD_W:0]    nx_reg, nx_next, ny_reg, ny_next;
    logic [4:0]          gx_reg, gx_next;
    logic [5:0]          gy_reg, gy_next;
    logic                ov_reg, ov_next;
    logic [2:0]          status_reg, status_next;
    logic [8:0]          plen_reg, plen_next;
    logic [4:0]          sx_reg, sx_next;
    logic [5:0]          sy_reg, sy_next;

    logic                map_we, map_wd, map_rd;
    logic [MAP_AW-1:0]   map_wa, map_ra;
    logic                open_we;
    logic [LA_W-1:0]     open_wa, open_ra;
    entry_t              open_wd, open_rd;
    logic                closed_we;
    logic [LA_W-1:0]     closed_wa, closed_ra;
    entry_t              closed_wd, closed_rd;
    logic                path_we;
    logic [LA_W-1:0]     path_wa, path_ra;
    cell_t               path_wd, path_rd;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            wall_mem[map_wa] <= map_wd;
        end
        map_rd <= wall_mem[map_ra];
        if (open_we)
        begin
            open_mem[open_wa] <= open_wd;
        end
        open_rd <= open_mem[open_ra];
        if (closed_we)
        begin
            closed_mem[closed_wa] <= closed_wd;
        end
        closed_rd <= closed_mem[closed_ra];
        if (path_we)
        begin
            path_mem[path_wa] <= path_wd;
        end
        path_rd <= path_mem[path_ra];
    end

    function automatic logic [COST_W-1:0] adiff(input logic [COORD_W:0] a,
                                                 input logic [COORD_W:0] b);
        logic [COST_W-1:0] r;
        r = (a > b) ? COST_W'(a - b) : COST_W'(b - a);
        return r;
    endfunction

    logic              in_ok, out_take;
    logic              nb_in;
    logic [COORD_W:0]  cx, cy;
    logic [COST_W-1:0] new_g;

    assign in_ok    = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid;
    assign cx       = (COORD_W + 1)'(cur_reg.x);
    assign cy       = (COORD_W + 1)'(cur_reg.y);
    assign new_g    = cur_reg.g + COST_W'(1);
    assign nb_in    = (nx_reg < (COORD_W + 1)'(GRID_COLS)) &&
                      (ny_reg < (COORD_W + 1)'(GRID_ROWS));

    logic ov_set;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        open_cnt_next   = open_cnt_reg;
        closed_cnt_next = closed_cnt_reg;
        path_cnt_next   = path_cnt_reg;
        idx_next        = idx_reg;
        best_next       = best_reg;
        best_f_next     = best_f_reg;
        cur_next        = cur_reg;
        me_next         = me_reg;
        nb_next         = nb_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        ov_next         = ov_reg;
        status_next     = status_reg;
        plen_next       = plen_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        ov_set          = 1'b0;
        map_we          = 1'b0;
        map_wa          = '0;
        map_wd          = 1'b0;
        map_ra          = '0;
        open_we         = 1'b0;
        open_wa         = '0;
        open_wd         = '0;
        open_ra         = '0;
        closed_we       = 1'b0;
        closed_wa       = '0;
        closed_wd       = '0;
        closed_ra       = '0;
        path_we         = 1'b0;
        path_wa         = '0;
        path_wd         = '0;
        path_ra         = '0;
        if (out_take)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                map_we = 1'b1;
                map_wa = clr_reg[MAP_AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (MAP_AW + 1)'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_ok)
                begin
                    sx_next = '0;
                    sy_next = '0;
                    case (command)
                        CMD_WRITE:
                        begin
                            if ((9)'(pos_x) < 9'(GRID_COLS) && (9)'(pos_y) < 9'(GRID_ROWS))
                            begin
                                map_we = 1'b1;
                                map_wa = MAP_AW'(32'(pos_y) * 32'(GRID_COLS) + 32'(pos_x));
                                map_wd = wall;
                            end
                            status_next = ST_WRITTEN;
                            plen_next   = 9'(path_cnt_reg);
                            ov_set      = 1'b1;
                        end
                        CMD_FIND:
                        begin
                            gx_next = goal_x;
                            gy_next = goal_y;
                            path_cnt_next   = '0;
                            closed_cnt_next = '0;
                            if ((9)'(pos_x) < 9'(GRID_COLS) && (9)'(pos_y) < 9'(GRID_ROWS))
                            begin
                                open_we = 1'b1;
                                open_wa = '0;
                                open_wd.x = XW'(pos_x);
                                open_wd.y = YW'(pos_y);
                                open_wd.g = '0;
                                open_wd.f = adiff((COORD_W + 1)'(pos_x),
                                                  (COORD_W + 1)'(goal_x)) +
                                            adiff((COORD_W + 1)'(pos_y),
                                                  (COORD_W + 1)'(goal_y));
                                open_wd.back = '0;
                                open_wd.has_back = 1'b0;
                                open_cnt_next = CNT_W'(1);
                                idx_next    = '0;
                                state_next  = S_SCAN;
                            end
                            else
                            begin
                                open_cnt_next = '0;
                                status_next = ST_NO_PATH;
                                plen_next   = '0;
                                ov_set      = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (9'(step_index) < 9'(path_cnt_reg))
                            begin
                                path_ra    = LA_W'(step_index);
                                state_next = S_RDPATH;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                plen_next   = 9'(path_cnt_reg);
                                ov_set      = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_RANGE;
                            plen_next   = 9'(path_cnt_reg);
                            ov_set      = 1'b1;
                        end
                    endcase
                end
            end
            S_RDPATH:
            begin
                status_next = ST_OK;
                plen_next   = 9'(path_cnt_reg);
                sx_next     = 5'(path_rd.x);
                sy_next     = 6'(path_rd.y);
                ov_set      = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                // scan open list for first lowest f
                if (open_cnt_reg == '0)
                begin
                    status_next = ST_NO_PATH;
                    plen_next   = '0;
                    path_cnt_next = '0;
                    ov_set      = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    open_ra    = LA_W'(idx_reg);
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (idx_reg == CNT_W'(1) || open_rd.f < best_f_reg)
                begin
                    best_next   = idx_reg - 1'b1;
                    best_f_next = open_rd.f;
                end
                if (idx_reg < open_cnt_reg)
                begin
                    open_ra  = LA_W'(idx_reg);
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    open_ra    = LA_W'(best_next);
                    state_next = S_POPRD;
                end
            end
            S_POPRD:
            begin
                cur_next   = open_rd;
                idx_next   = best_reg;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                // compact the open list over the popped slot
                if (idx_reg + 1'b1 < open_cnt_reg)
                begin
                    open_ra    = LA_W'(idx_reg + 1'b1);
                    state_next = S_SHIFTW;
                end
                else
                begin
                    open_cnt_next = open_cnt_reg - 1'b1;
                    state_next    = S_CLOSE;
                end
            end
            S_SHIFTW:
            begin
                open_we    = 1'b1;
                open_wa    = LA_W'(idx_reg);
                open_wd    = open_rd;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHIFT;
            end
            S_CLOSE:
            begin
                if (closed_cnt_reg >= CNT_W'(LIST_DEPTH))
                begin
                    status_next = ST_OVERFLOW;
                    plen_next   = '0;
                    path_cnt_next = '0;
                    ov_set      = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    closed_we = 1'b1;
                    closed_wa = LA_W'(closed_cnt_reg);
                    closed_wd = cur_reg;
                    me_next   = LA_W'(closed_cnt_reg);
                    closed_cnt_next = closed_cnt_reg + 1'b1;
                    if (cx == (COORD_W + 1)'(gx_reg) && cy == (COORD_W + 1)'(gy_reg))
                    begin
                        path_cnt_next = '0;
                        idx_next      = CNT_W'(closed_cnt_reg);
                        state_next    = S_BUILD;
                    end
                    else
                    begin
                        nb_next    = '0;
                        state_next = S_NB;
                    end
                end
            end
            S_NB:
            begin
                if (nb_reg == 3'd4)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    case (nb_reg[1:0])
                        2'd0:
                        begin
                            nx_next = cx;
                            ny_next = cy + 1'b1;
                        end
                        2'd1:
                        begin
                            nx_next = cx + 1'b1;
                            ny_next = cy;
                        end
                        2'd2:
                        begin
                            nx_next = cx;
                            ny_next = cy - 1'b1;
                        end
                        default:
                        begin
                            nx_next = cx - 1'b1;
                            ny_next = cy;
                        end
                    endcase
                    state_next = S_NBMAP;
                end
            end
            S_NBMAP:
            begin
                // below zero wraps to a large value and fails the bound test
                if (nb_in)
                begin
                    map_ra     = MAP_AW'(32'(ny_reg) * 32'(GRID_COLS) + 32'(nx_reg));
                    idx_next   = '0;
                    state_next = S_CSCAN;
                end
                else
                begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_NB;
                end
            end
            S_CSCAN:
            begin
                if (map_rd)
                begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_NB;
                end
                else if (closed_cnt_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    closed_ra  = '0;
                    idx_next   = CNT_W'(1);
                    state_next = S_CSCANW;
                end
            end
            S_CSCANW:
            begin
                if ((COORD_W + 1)'(closed_rd.x) == nx_reg &&
                    (COORD_W + 1)'(closed_rd.y) == ny_reg)
                begin
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_NB;
                end
                else if (idx_reg < closed_cnt_reg)
                begin
                    closed_ra = LA_W'(idx_reg);
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (open_cnt_reg >= CNT_W'(LIST_DEPTH))
                begin
                    status_next = ST_OVERFLOW;
                    plen_next   = '0;
                    path_cnt_next = '0;
                    ov_set      = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    open_we = 1'b1;
                    open_wa = LA_W'(open_cnt_reg);
                    open_wd.x = XW'(nx_reg);
                    open_wd.y = YW'(ny_reg);
                    open_wd.g = new_g;
                    open_wd.f = new_g + adiff(nx_reg, (COORD_W + 1)'(gx_reg)) +
                                adiff(ny_reg, (COORD_W + 1)'(gy_reg));
                    open_wd.back = me_reg;
                    open_wd.has_back = 1'b1;
                    open_cnt_next = open_cnt_reg + 1'b1;
                    nb_next    = nb_reg + 1'b1;
                    state_next = S_NB;
                end
            end
            S_BUILD:
            begin
                closed_ra  = LA_W'(idx_reg);
                state_next = S_BUILDW;
            end
            S_BUILDW:
            begin
                path_we = 1'b1;
                path_wa = LA_W'(path_cnt_reg);
                path_wd.x = closed_rd.x;
                path_wd.y = closed_rd.y;
                path_cnt_next = path_cnt_reg + 1'b1;
                if (!closed_rd.has_back || CNT_W'(closed_rd.back) >= idx_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = CNT_W'(closed_rd.back);
                    state_next = S_BUILD;
                end
            end
            S_DONE:
            begin
                status_next = ST_OK;
                plen_next   = 9'(path_cnt_reg);
                ov_set      = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (ov_set)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            open_cnt_reg   <= '0;
            closed_cnt_reg <= '0;
            path_cnt_reg   <= '0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            open_cnt_reg   <= open_cnt_next;
            closed_cnt_reg <= closed_cnt_next;
            path_cnt_reg   <= path_cnt_next;
            ov_reg         <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        best_f_reg <= best_f_next;
        cur_reg    <= cur_next;
        me_reg     <= me_next;
        nb_reg     <= nb_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        status_reg <= status_next;
        plen_reg   <= plen_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
    end

    assign out_valid   = ov_reg;
    assign status      = status_reg;
    assign path_length = plen_reg;
    assign step_x      = sx_reg;
    assign step_y      = sy_reg;

endmodule

FILE: verif/tb_grid_astar_path_finder_core.sv
// self-checking testbench for the grid a* path finder core
`timescale 1ns / 100ps

module tb_grid_astar_path_finder_core;
    import gapf_pkg::*;

    localparam int COLS  = 32;
    localparam int ROWS  = 64;
    localparam int DEPTH = 256;

    typedef struct {
        cmd_t       command;
        logic [4:0] pos_x;
        logic [5:0] pos_y;
        logic       wall;
        logic [4:0] goal_x;
        logic [5:0] goal_y;
        logic [7:0] step_index;
        bit         drain;
    } cmd_word_t;

    typedef struct {
        logic [2:0] status;
        logic [8:0] path_length;
        logic [4:0] step_x;
        logic [5:0] step_y;
    } result_word_t;

    typedef struct {
        int x;
        int y;
        int g;
        int f;
        int back;
        bit has_back;
    } node_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] command;
    logic [4:0] pos_x;
    logic [5:0] pos_y;
    logic       wall;
    logic [4:0] goal_x;
    logic [5:0] goal_y;
    logic [7:0] step_index;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [8:0] path_length;
    logic [4:0] step_x;
    logic [5:0] step_y;

    grid_astar_path_finder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .wall       (wall),
        .goal_x     (goal_x),
        .goal_y     (goal_y),
        .step_index (step_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .path_length(path_length),
        .step_x     (step_x),
        .step_y     (step_y)
    );

    // predictor state
    bit    wall_cells [COLS * ROWS];
    node_t frontier [DEPTH];
    node_t visited [DEPTH];
    int    route_x [DEPTH];
    int    route_y [DEPTH];
    int    frontier_n;
    int    visited_n;
    int    route_n;

    cmd_word_t    cmd_q[$];
    result_word_t pending_results[$];
    int           total_words;
    int           words_taken;
    int           results_taken;
    int           mismatches;
    bit           in_fire;
    int           send_wait;
    int           recv_wait;

    function bit add_frontier(int x, int y, int g, int back, bit has_back, int gx, int gy);
        if (frontier_n >= DEPTH)
            return 0;
        frontier[frontier_n].x = x;
        frontier[frontier_n].y = y;
        frontier[frontier_n].g = g;
        frontier[frontier_n].f = g + (x > gx ? x - gx : gx - x) + (y > gy ? y - gy : gy - y);
        frontier[frontier_n].back = back;
        frontier[frontier_n].has_back = has_back;
        frontier_n++;
        return 1;
    endfunction

    function bit cell_open(int x, int y);
        if (x < 0 || x >= COLS || y < 0 || y >= ROWS)
            return 0;
        if (wall_cells[y * COLS + x])
            return 0;
        for (int j = 0; j < visited_n; j++)
            if (visited[j].x == x && visited[j].y == y)
                return 0;
        return 1;
    endfunction

    function logic [2:0] plan_route(int sx, int sy, int gx, int gy);
        int    best;
        int    me;
        int    idx;
        int    nx;
        int    ny;
        node_t cur;
        route_n = 0;
        frontier_n = 0;
        visited_n = 0;
        if (sx >= COLS || sy >= ROWS)
            return ST_NO_PATH;
        if (!add_frontier(sx, sy, 0, 0, 0, gx, gy))
            return ST_OVERFLOW;
        while (frontier_n > 0) begin
            best = 0;
            for (int i = 1; i < frontier_n; i++)
                if (frontier[i].f < frontier[best].f)
                    best = i;
            cur = frontier[best];
            for (int i = best; i + 1 < frontier_n; i++)
                frontier[i] = frontier[i + 1];
            frontier_n--;
            if (visited_n >= DEPTH)
                return ST_OVERFLOW;
            me = visited_n;
            visited[visited_n++] = cur;
            if (cur.x == gx && cur.y == gy) begin
                idx = me;
                forever begin
                    route_x[route_n] = visited[idx].x;
                    route_y[route_n] = visited[idx].y;
                    route_n++;
                    if (!visited[idx].has_back || visited[idx].back >= idx)
                        break;
                    idx = visited[idx].back;
                end
                return ST_OK;
            end
            for (int k = 0; k < 4; k++) begin
                nx = cur.x + (k == 1 ? 1 : (k == 3 ? -1 : 0));
                ny = cur.y + (k == 0 ? 1 : (k == 2 ? -1 : 0));
                if (cell_open(nx, ny))
                    if (!add_frontier(nx, ny, cur.g + 1, me, 1, gx, gy))
                        return ST_OVERFLOW;
            end
        end
        return ST_NO_PATH;
    endfunction

    function result_word_t predict_result(cmd_word_t w);
        result_word_t r;
        r.status = ST_RANGE;
        r.step_x = '0;
        r.step_y = '0;
        case (w.command)
            CMD_WRITE: begin
                wall_cells[int'(w.pos_y) * COLS + int'(w.pos_x)] = w.wall;
                r.status = ST_WRITTEN;
            end
            CMD_FIND: begin
                r.status = plan_route(w.pos_x, w.pos_y, w.goal_x, w.goal_y);
                if (r.status != ST_OK)
                    route_n = 0;
            end
            CMD_READ: begin
                if (int'(w.step_index) < route_n) begin
                    r.status = ST_OK;
                    r.step_x = 5'(route_x[w.step_index]);
                    r.step_y = 6'(route_y[w.step_index]);
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.path_length = 9'(route_n);
        return r;
    endfunction

    task add_word(cmd_t c, int px, int py, int wl, int gx, int gy, int si, bit dr = 0);
        cmd_word_t w;
        w.command = c;
        w.pos_x = 5'(px);
        w.pos_y = 6'(py);
        w.wall = 1'(wl);
        w.goal_x = 5'(gx);
        w.goal_y = 6'(gy);
        w.step_index = 8'(si);
        w.drain = dr;
        cmd_q.push_back(w);
    endtask

    function int clamp(int v, int hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        rst_n = 0;
        in_valid = 0;
        out_stall = 0;
        command = CMD_NONE;
        pos_x = 0;
        pos_y = 0;
        wall = 0;
        goal_x = 0;
        goal_y = 0;
        step_index = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    initial begin
        #2_000_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // stimulus
    initial begin
        int sx;
        int sy;
        int pick;
        add_word(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_word(CMD_NONE, 31, 63, 1, 31, 63, 255);
        add_word(CMD_WRITE, 31, 63, 1, 0, 0, 0);
        add_word(CMD_WRITE, 31, 63, 0, 31, 63, 255);
        add_word(CMD_FIND, 0, 0, 0, 3, 2, 0);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 5);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 6);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 255);
        add_word(CMD_FIND, 5, 5, 0, 5, 5, 0);
        add_word(CMD_WRITE, 10, 10, 1, 0, 0, 0);
        add_word(CMD_FIND, 10, 10, 0, 12, 10, 0);
        add_word(CMD_WRITE, 1, 0, 1, 0, 0, 0);
        add_word(CMD_WRITE, 0, 1, 1, 0, 0, 0);
        add_word(CMD_FIND, 0, 0, 0, 4, 4, 0);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 0);
        add_word(CMD_WRITE, 20, 41, 1, 0, 0, 0);
        add_word(CMD_WRITE, 21, 40, 1, 0, 0, 0);
        add_word(CMD_WRITE, 20, 39, 1, 0, 0, 0);
        add_word(CMD_WRITE, 19, 40, 1, 0, 0, 0);
        add_word(CMD_FIND, 20, 30, 0, 20, 40, 0, 1);
        add_word(CMD_FIND, 31, 63, 0, 0, 0, 0);
        add_word(CMD_READ, 0, 0, 0, 0, 0, 94);
        add_word(CMD_WRITE, 20, 39, 0, 0, 0, 0);
        add_word(CMD_WRITE, 10, 10, 0, 0, 0, 0);
        for (int n = 0; n < 115; n++) begin
            pick = $urandom_range(0, 99);
            sx = $urandom_range(0, 31);
            sy = $urandom_range(0, 63);
            if (pick < 35)
                add_word(CMD_WRITE, sx, sy, $urandom_range(0, 1), $urandom_range(0, 31),
                         $urandom_range(0, 63), $urandom_range(0, 255), n == 70);
            else if (pick < 60)
                add_word(CMD_FIND, sx, sy, $urandom_range(0, 1),
                         clamp(sx + $urandom_range(0, 10) - 5, 31),
                         clamp(sy + $urandom_range(0, 10) - 5, 63), $urandom_range(0, 255),
                         n == 70);
            else if (pick < 95)
                add_word(CMD_READ, sx, sy, $urandom_range(0, 1), $urandom_range(0, 31),
                         $urandom_range(0, 63),
                         $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 12), n == 70);
            else
                add_word(CMD_NONE, sx, sy, $urandom_range(0, 1), $urandom_range(0, 31),
                         $urandom_range(0, 63), $urandom_range(0, 255), n == 70);
        end
        total_words = cmd_q.size();
        wait (rst_n && words_taken == total_words);
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // driver
    always @(negedge clk) begin
        cmd_word_t w;
        logic      nxt_valid;
        if (rst_n) begin
            nxt_valid = in_valid;
            if (!in_valid || in_fire) begin
                nxt_valid = 0;
                if (send_wait > 0)
                    send_wait--;
                else if (cmd_q.size() > 0 && !(cmd_q[0].drain && pending_results.size() > 0))
                begin
                    w = cmd_q.pop_front();
                    command <= w.command;
                    pos_x <= w.pos_x;
                    pos_y <= w.pos_y;
                    wall <= w.wall;
                    goal_x <= w.goal_x;
                    goal_y <= w.goal_y;
                    step_index <= w.step_index;
                    nxt_valid = 1;
                    send_wait = (words_taken % 50 < 12) ? 0 : $urandom_range(0, 14);
                end
            end
            in_valid <= nxt_valid;
            if (recv_wait > 0) begin
                recv_wait--;
                out_stall <= 1;
            end
            else
                out_stall <= 0;
        end
    end

    // monitor
    always @(posedge clk) begin
        cmd_word_t    w;
        result_word_t r;
        in_fire = in_valid && !in_stall;
        if (in_fire) begin
            w.command = cmd_t'(command);
            w.pos_x = pos_x;
            w.pos_y = pos_y;
            w.wall = wall;
            w.goal_x = goal_x;
            w.goal_y = goal_y;
            w.step_index = step_index;
            w.drain = 0;
            pending_results.push_back(predict_result(w));
            words_taken++;
        end
        if (rst_n && out_valid && !out_stall) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else begin
                r = pending_results.pop_front();
                if (status !== r.status) begin
                    $error("status expected %0d actual %0d", r.status, status);
                    mismatches++;
                end
                if (path_length !== r.path_length) begin
                    $error("path_length expected %0d actual %0d", r.path_length, path_length);
                    mismatches++;
                end
                if (step_x !== r.step_x) begin
                    $error("step_x expected %0d actual %0d", r.step_x, step_x);
                    mismatches++;
                end
                if (step_y !== r.step_y) begin
                    $error("step_y expected %0d actual %0d", r.step_y, step_y);
                    mismatches++;
                end
            end
            if (results_taken == 40)
                recv_wait = 400;
            else
                recv_wait = (results_taken % 50 > 40) ? 0 : $urandom_range(0, 14);
        end
    end

endmodule

FILE: files.f
rtl/core/gapf_pkg.sv
rtl/core/grid_astar_path_finder_core.sv
verif/tb_grid_astar_path_finder_core.sv
